// ===== src/kylf_pkg.sv =====
// kylf_pkg: shared types and constants for the keyed length framer.
// Holds header geometry, event codes, register indexes and the config and
// result structs. No dependencies.
package kylf_pkg;

  localparam int HDR_BYTES  = 13;  // key + version + length
  localparam int KEEP_FROM  = 9;   // first byte kept after a bad key or version
  localparam int KEY_BYTES  = 8;

  localparam int FILL_W     = 4;   // enough for header positions 0..12
  localparam int BYTE_W     = 8;
  localparam int KEY_W      = 64;
  localparam int LEN_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [LEN_W-1:0] LENGTH_LIMIT_RST = 32'd65544;

  typedef enum logic [1:0] {
    EV_START   = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_BAD_HDR = 2'd2,
    EV_BAD_LEN = 2'd3
  } kylf_event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_KEY     = 2'd0,
    REG_FRAME_VERSION = 2'd1,
    REG_LENGTH_LIMIT  = 2'd2
  } kylf_reg_t;

  typedef struct packed {
    logic [KEY_W-1:0]  frame_key;
    logic [BYTE_W-1:0] frame_version;
    logic [LEN_W-1:0]  length_limit;
  } kylf_cfg_t;

  typedef struct packed {
    kylf_event_t       event_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  frame_length;
    logic              last_byte;
  } kylf_result_t;

endpackage

// ===== src/kylf_cfg.sv =====
// kylf_cfg: configuration register file of the keyed length framer.
// Depends on kylf_pkg for register indexes, widths and reset values.
module kylf_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [kylf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kylf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output kylf_pkg::kylf_cfg_t              cfg
);
  import kylf_pkg::*;

  kylf_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_key     <= '0;
      cfg_r.frame_version <= '0;
      cfg_r.length_limit  <= LENGTH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (kylf_reg_t'(cfg_index))
        REG_FRAME_KEY:     cfg_r.frame_key     <= cfg_data[KEY_W-1:0];
        REG_FRAME_VERSION: cfg_r.frame_version <= cfg_data[BYTE_W-1:0];
        REG_LENGTH_LIMIT:  cfg_r.length_limit  <= cfg_data[LEN_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/kylf_core.sv =====
// kylf_core: header collection, header check and payload counting.
// Produces at most one result per processed byte, combinationally.
// Depends on kylf_pkg for types and header geometry.
module kylf_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [kylf_pkg::BYTE_W-1:0]   byte_in,
  input  kylf_pkg::kylf_cfg_t           cfg,
  output logic                          res_valid,
  output kylf_pkg::kylf_result_t        res
);
  import kylf_pkg::*;

  logic [BYTE_W-1:0] hdr_r [HDR_BYTES];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0]  remain_r, remain_nxt;
  logic              in_payload_r, in_payload_nxt;

  logic [KEY_W-1:0]  key;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  remain_dec;
  logic              hdr_done;
  logic              bad_hdr;
  logic              bad_len;

  always_comb begin
    for (int i = 0; i < KEY_BYTES; i++) begin
      key[i*BYTE_W +: BYTE_W] = hdr_r[i];
    end
  end

  // The length's top byte is the one arriving now.
  assign len        = {byte_in, hdr_r[KEEP_FROM+2], hdr_r[KEEP_FROM+1], hdr_r[KEEP_FROM]};
  assign hdr_done   = (fill_r == FILL_W'(HDR_BYTES - 1));
  assign bad_hdr    = (key != cfg.frame_key) || (hdr_r[KEY_BYTES] != cfg.frame_version);
  assign bad_len    = (len == '0) || (len > cfg.length_limit);
  assign remain_dec = remain_r - LEN_W'(1);

  always_comb begin
    fill_nxt       = fill_r;
    remain_nxt     = remain_r;
    in_payload_nxt = in_payload_r;
    res_valid      = 1'b0;
    res            = '{event_kind: EV_PAYLOAD, payload_byte: '0, frame_length: '0,
                       last_byte: 1'b0};
    if (step) begin
      if (in_payload_r) begin
        remain_nxt    = remain_dec;
        res_valid     = 1'b1;
        res.payload_byte = byte_in;
        if (remain_dec == '0) begin
          in_payload_nxt = 1'b0;
          res.last_byte  = 1'b1;
        end
      end else if (!hdr_done) begin
        fill_nxt = fill_r + FILL_W'(1);
      end else if (bad_hdr) begin
        fill_nxt       = FILL_W'(HDR_BYTES - KEEP_FROM);
        res_valid      = 1'b1;
        res.event_kind = EV_BAD_HDR;
      end else if (bad_len) begin
        fill_nxt       = '0;
        res_valid      = 1'b1;
        res.event_kind = EV_BAD_LEN;
      end else begin
        fill_nxt         = '0;
        remain_nxt       = len;
        in_payload_nxt   = 1'b1;
        res_valid        = 1'b1;
        res.event_kind   = EV_START;
        res.frame_length = len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      remain_r     <= '0;
      in_payload_r <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      remain_r     <= remain_nxt;
      in_payload_r <= in_payload_nxt;
    end
  end

  // Header bytes: written before they are ever read, so no reset.
  always_ff @(posedge clk) begin
    if (step && !in_payload_r) begin
      if (hdr_done && bad_hdr) begin
        // keep the last four header bytes as the start of the next header
        for (int i = 0; i < HDR_BYTES - KEEP_FROM - 1; i++) begin
          hdr_r[i] <= hdr_r[KEEP_FROM + i];
        end
        hdr_r[HDR_BYTES - KEEP_FROM - 1] <= byte_in;
      end else begin
        hdr_r[fill_r] <= byte_in;
      end
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < FILL_W'(HDR_BYTES))
    else $error("header fill out of range");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> remain_r != '0)
    else $error("payload mode with zero bytes remaining");

  a_last_exits: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_payload_r && remain_r == LEN_W'(1) |=> !in_payload_r)
    else $error("payload mode kept after the last byte");

  a_resync_fill: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.event_kind == EV_BAD_HDR |=>
      fill_r == FILL_W'(HDR_BYTES - KEEP_FROM) && !in_payload_r)
    else $error("bad header did not keep the trailing bytes");

endmodule

// ===== src/keyed_length_framer.sv =====
// keyed_length_framer: top level of the byte-stream deframer.
// Instantiates kylf_cfg and kylf_core; uses kylf_pkg for types and widths.
//
// Takes one stream byte per transaction and finds frames of the form
// 8-byte key, 1-byte version, 4-byte little-endian length, then payload.
// A byte is captured in an input register and checked against the header
// state in a single pass once it advances from there (it is held while the
// output register is blocked); its result (if any) lands in the output
// register, so a new byte is taken every cycle while the output side keeps up.
// A completed header yields one result: frame
// start with its length, bad key or version (the last four header bytes are
// kept and the search resumes from them), or bad length (zero or above
// length_limit; all thirteen bytes are dropped). After a frame start every
// byte is passed through as a payload result, the final one flagged with
// out_last_byte. Header bytes before the thirteenth produce no result.
// Write configuration only while no transaction is in flight.
module keyed_length_framer (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kylf_pkg::BYTE_W-1:0]      in_stream_byte,
  // results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_event_kind,
  output logic [kylf_pkg::BYTE_W-1:0]      out_payload_byte,
  output logic [kylf_pkg::LEN_W-1:0]       out_frame_length,
  output logic                             out_last_byte,
  // configuration
  input  logic                             cfg_we,
  input  logic [kylf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kylf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kylf_pkg::*;

  kylf_cfg_t         cfg;
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_valid_r;
  kylf_result_t      out_res_r;
  logic              out_block;
  logic              s1_adv;
  logic              in_take;
  logic              res_valid;
  kylf_result_t      res;

  kylf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The output register is blocked only while it holds a result that is stalled.
  assign out_block = out_valid_r && out_stall;
  // Advance the captured byte into the core whenever the result has a place to go.
  assign s1_adv    = s1_valid_r && !out_block;
  // Hold the input while the captured byte cannot advance.
  assign in_stall  = s1_valid_r && out_block;
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  kylf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .byte_in   (s1_byte_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (!out_block) begin
        out_valid_r <= s1_adv && res_valid;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_stream_byte;
    end
    if (!out_block) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_res_r.event_kind;
  assign out_payload_byte = out_res_r.payload_byte;
  assign out_frame_length = out_res_r.frame_length;
  assign out_last_byte    = out_res_r.last_byte;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_block |=> s1_valid_r && $stable(s1_byte_r))
    else $error("captured byte lost while the output was blocked");

  a_core_idle_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_block |-> !s1_adv)
    else $error("core stepped while the result register was full");

  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.event_kind != EV_PAYLOAD |->
      out_res_r.payload_byte == '0 && !out_res_r.last_byte)
    else $error("payload fields set on a header event");

endmodule
